FILE: rtl/bbs_pkg.sv
// Shared types, constants and codes for the billboard sprite pixel shader.
`timescale 1ns / 1ps
package bbs_pkg;
	localparam int unsigned ScreenW = 640;
	localparam int unsigned ScreenH = 480;
	localparam int unsigned TexSize = 64;
	localparam int unsigned TexBits = 6;
	localparam logic [23:0] Magenta = 24'hFF00FF;

	typedef enum logic [1:0] {
		CMD_TEXEL = 2'd0,
		CMD_DEPTH = 2'd1,
		CMD_SPRITE = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_PLAYER_X = 3'd0,
		REG_PLAYER_Y = 3'd1,
		REG_DIR_X = 3'd2,
		REG_DIR_Y = 3'd3,
		REG_PLANE_X = 3'd4,
		REG_PLANE_Y = 3'd5
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_DIV_DEPTH, ST_DIV_CENTER, ST_DIV_HEIGHT, ST_BOUNDS,
		ST_Q_READ, ST_Q_DIVX, ST_Q_DIVY, ST_Q_TEX, ST_Q_TEXWAIT, ST_OUT
	} state_t;

	// Request and response between sequencer and divider.
	typedef struct packed {
		logic start;
		logic signed [63:0] num;
		logic signed [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [63:0] quo;
	} div_rsp_t;

	function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic signed [63:0] clampr(input logic signed [63:0] v,
		input logic signed [63:0] lo, input logic signed [63:0] hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction
endpackage

FILE: rtl/billboard_sprite_pixel_shader.sv
// Top level: command decode, sequencer, stores and sprite state.
`timescale 1ns / 1ps
// Billboard sprite unit for a raycaster in Q16.16 fixed point.
// Input channel in_valid/in_ready carries one command per beat: texel write,
// column depth write, set sprite, or pixel query. Each beat yields exactly one
// result beat on out_valid/out_ready (draw, color, echoed column and row).
// Config channel cfg_valid/cfg_ready writes the six camera registers by index;
// it is always ready and must be used only while the block is idle.
// Set sprite runs the multiply steps and then up to three divisions (depth,
// center, height) on one shared divider; a pixel query runs up to two
// divisions (texture x and y).
// One item is in work at a time; in_ready is low until the result is taken.
// The shared 64-bit divider, one quotient bit per cycle, does every division.
// Reset clears sprite state and config registers to their defaults; texture
// and depth stores are undefined until written. A stalled receiver holds the
// result register and the block takes no new item until it is taken.
module billboard_sprite_pixel_shader
	import bbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] command,
	input logic [9:0] column,
	input logic [8:0] row,
	input logic [5:0] tex_col,
	input logic [5:0] tex_row,
	input logic [23:0] texel_color,
	input logic [23:0] wall_depth,
	input logic [23:0] sprite_x,
	input logic [23:0] sprite_y,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [23:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic draw,
	output logic [23:0] color,
	output logic [9:0] out_column,
	output logic [8:0] out_row
);
	logic [23:0] player_x_q, player_y_q;
	logic signed [18:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic signed [63:0] cam_depth_q, center_q, height_q;
	logic signed [11:0] bsx_q, bex_q;
	logic signed [10:0] bsy_q, bey_q;

	logic [23:0] tex_mem [TexSize*TexSize];
	logic [23:0] depth_mem [ScreenW];
	logic [23:0] tex_rd_q, depth_rd_q;

	state_t state_q, state_d;
	logic [1:0] cmd_q;
	logic [9:0] col_q;
	logic [8:0] row_q;
	logic [23:0] sx_q, sy_q;
	logic [1:0] mstep_q;
	logic signed [63:0] det_q, tn_q, dn_q, tx_q;
	logic [0:0] acc_q;
	logic [TexBits-1:0] txi_q, tyi_q;
	logic draw_q, pre_q;
	logic [23:0] color_q;

	div_req_t dreq;
	div_rsp_t drsp;

	bbs_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	// Config registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q <= '0;
			player_y_q <= '0;
			dir_x_q <= 19'sd65536;
			dir_y_q <= '0;
			plane_x_q <= '0;
			plane_y_q <= 19'sd43254;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PLAYER_X: player_x_q <= cfg_data;
				REG_PLAYER_Y: player_y_q <= cfg_data;
				REG_DIR_X: dir_x_q <= cfg_data[18:0];
				REG_DIR_Y: dir_y_q <= cfg_data[18:0];
				REG_PLANE_X: plane_x_q <= cfg_data[18:0];
				REG_PLANE_Y: plane_y_q <= cfg_data[18:0];
				default: ;
			endcase
		end
	end

	// Stores: one write port, one registered read port each.
	logic [11:0] tex_addr;
	assign tex_addr = {tyi_q, txi_q};
	always_ff @(posedge clk) begin
		if (in_valid && in_ready && command == CMD_TEXEL)
			tex_mem[{tex_row, tex_col}] <= texel_color;
		tex_rd_q <= tex_mem[tex_addr];
	end
	always_ff @(posedge clk) begin
		if (in_valid && in_ready && command == CMD_DEPTH && column < 10'(ScreenW))
			depth_mem[column] <= wall_depth;
		if (col_q < 10'(ScreenW))
			depth_rd_q <= depth_mem[col_q];
		else
			depth_rd_q <= '0;
	end

	// Multiplier operands: one 25x19 signed product per cycle, and a second one (prod2) at mstep_q 2 and 3.
	logic signed [24:0] dx, dy;
	logic signed [24:0] ma;
	logic signed [18:0] mb;
	logic signed [43:0] prod;
	assign dx = $signed({1'b0, sx_q}) - $signed({1'b0, player_x_q});
	assign dy = $signed({1'b0, sy_q}) - $signed({1'b0, player_y_q});

	always_comb begin
		ma = '0;
		mb = '0;
		case (mstep_q)
			2'd0: begin ma = 25'(plane_x_q); mb = dir_y_q; end
			2'd1: begin ma = 25'(plane_y_q); mb = dir_x_q; end
			2'd2: begin ma = dx; mb = dir_y_q; end
			default: begin ma = dy; mb = dir_x_q; end
		endcase
	end
	assign prod = ma * mb;

	logic signed [43:0] prod2;
	logic signed [24:0] ma2;
	logic signed [18:0] mb2;
	always_comb begin
		case (mstep_q)
			2'd2: begin ma2 = dy; mb2 = plane_x_q; end
			2'd3: begin ma2 = dx; mb2 = plane_y_q; end
			default: begin ma2 = '0; mb2 = '0; end
		endcase
	end
	assign prod2 = ma2 * mb2;

	logic signed [63:0] half, h_abs;
	assign half = height_q >>> 1;
	assign h_abs = (drsp.quo < 0) ? -drsp.quo : drsp.quo;

	logic signed [63:0] hnew, hhalf;
	assign hnew = sat32(h_abs);
	assign hhalf = hnew >>> 1;

	logic signed [63:0] tx_cl, ty_cl;
	assign tx_cl = clampr(tx_q, 64'sd0, 64'(TexSize - 1));
	assign ty_cl = clampr(drsp.quo >>> 8, 64'sd0, 64'(TexSize - 1));

	logic in_box;
	assign in_box = height_q > 0 && cam_depth_q > 0 && col_q != 10'd0 &&
		col_q < 10'(ScreenW) && $signed({2'b0, col_q}) >= bsx_q &&
		$signed({2'b0, col_q}) < bex_q && $signed({2'b0, row_q}) >= bsy_q &&
		$signed({2'b0, row_q}) < bey_q;

	always_comb begin
		state_d = state_q;
		dreq = '0;
		case (state_q)
			ST_IDLE: if (in_valid && in_ready) begin
				if (command == CMD_SPRITE)
					state_d = ST_MUL;
				else if (command == CMD_QUERY)
					state_d = ST_Q_READ;
				else
					state_d = ST_OUT;
			end
			ST_MUL: if (mstep_q == 2'd3) begin
				state_d = ST_DIV_DEPTH;
			end
			ST_DIV_DEPTH: begin
				dreq.start = acc_q[0];
				dreq.num = dn_q <<< 16;
				dreq.den = det_q;
				if (det_q == 0 || dn_q == 0)
					state_d = ST_OUT;
				else if (drsp.done)
					state_d = ST_DIV_CENTER;
			end
			ST_DIV_CENTER: begin
				dreq.start = acc_q[0];
				dreq.num = 64'(ScreenW / 2) * (tn_q + dn_q);
				dreq.den = dn_q;
				if (drsp.done)
					state_d = ST_DIV_HEIGHT;
			end
			ST_DIV_HEIGHT: begin
				dreq.start = acc_q[0];
				dreq.num = 64'(ScreenH) * det_q;
				dreq.den = dn_q;
				if (drsp.done)
					state_d = ST_BOUNDS;
			end
			ST_BOUNDS: state_d = ST_OUT;
			ST_Q_READ: begin
				if (!in_box)
					state_d = ST_OUT;
				else
					state_d = ST_Q_DIVX;
			end
			ST_Q_DIVX: begin
				dreq.start = acc_q[0];
				dreq.num = (64'sd256 * ($signed({54'b0, col_q}) - (center_q - half)))
					* 64'(TexSize);
				dreq.den = height_q;
				if (cam_depth_q >= $signed({40'b0, depth_rd_q}))
					state_d = ST_OUT;
				else if (drsp.done)
					state_d = ST_Q_DIVY;
			end
			ST_Q_DIVY: begin
				dreq.start = acc_q[0];
				dreq.num = ($signed({55'b0, row_q}) * 64'sd256 - 64'(ScreenH) * 64'sd128
					+ height_q * 64'sd128) * 64'(TexSize);
				dreq.den = height_q;
				if (drsp.done)
					state_d = ST_Q_TEX;
			end
			ST_Q_TEX: state_d = ST_Q_TEXWAIT;
			ST_Q_TEXWAIT: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			mstep_q <= '0;
			acc_q <= '0;
			cam_depth_q <= '0;
			center_q <= '0;
			height_q <= '0;
			bsx_q <= '0;
			bex_q <= '0;
			bsy_q <= '0;
			bey_q <= '0;
		end else begin
			state_q <= state_d;
			// acc_q[0] marks the first cycle of a division state.
			acc_q <= state_d != state_q;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			if (state_q == ST_OUT)
				out_valid <= 1'b1;
			if (state_q == ST_IDLE)
				mstep_q <= '0;
			else if (state_q == ST_MUL)
				mstep_q <= mstep_q + 2'd1;
			if (state_q == ST_DIV_DEPTH && (det_q == 0 || dn_q == 0)) begin
				cam_depth_q <= '0;
				center_q <= '0;
				height_q <= '0;
				bsx_q <= '0;
				bex_q <= '0;
				bsy_q <= '0;
				bey_q <= '0;
			end
			if (state_q == ST_DIV_DEPTH && drsp.done)
				cam_depth_q <= sat32(drsp.quo);
			if (state_q == ST_DIV_CENTER && drsp.done)
				center_q <= sat32(drsp.quo);
			if (state_q == ST_DIV_HEIGHT && drsp.done) begin
				height_q <= hnew;
				bsy_q <= 11'(clampr(64'(ScreenH / 2) - hhalf, 64'sd0, 64'(ScreenH)));
				bey_q <= 11'(clampr(64'(ScreenH / 2) + hhalf, 64'sd0, 64'(ScreenH)));
				bsx_q <= 12'(clampr(center_q - hhalf, 64'sd0, 64'(ScreenW)));
				bex_q <= 12'(clampr(center_q + hhalf, 64'sd0, 64'(ScreenW)));
			end
		end
	end

	// Datapath registers, no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			col_q <= column;
			row_q <= row;
			sx_q <= sprite_x;
			sy_q <= sprite_y;
			pre_q <= 1'b0;
		end
		if (state_q == ST_MUL) begin
			case (mstep_q)
				2'd0: det_q <= 64'(prod);
				2'd1: det_q <= det_q - 64'(prod);
				2'd2: begin tn_q <= 64'(prod); dn_q <= 64'(prod2); end
				default: begin tn_q <= tn_q - 64'(prod); dn_q <= dn_q - 64'(prod2); end
			endcase
		end
		if (state_q == ST_Q_DIVX && drsp.done) begin
			tx_q <= drsp.quo >>> 8;
		end
		if (state_q == ST_Q_DIVY && drsp.done) begin
			txi_q <= TexBits'(tx_cl);
			tyi_q <= TexBits'(ty_cl);
		end
		if (state_q == ST_Q_TEXWAIT)
			pre_q <= 1'b1;
		if (state_q == ST_OUT) begin
			draw_q <= pre_q && cmd_q == CMD_QUERY && tex_rd_q != Magenta;
			color_q <= (pre_q && cmd_q == CMD_QUERY && tex_rd_q != Magenta)
				? tex_rd_q : 24'd0;
			out_column <= col_q;
			out_row <= row_q;
		end
	end

	assign draw = draw_q;
	assign color = color_q;

	assert property (@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=>
		out_valid && $stable(color) && $stable(draw))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> !out_valid)
		else $error("ready while result pending");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid && !draw |-> color == 24'd0)
		else $error("color set without draw");
	assert property (@(posedge clk) disable iff (!arst_n) state_q != ST_IDLE |-> !in_ready)
		else $error("ready while busy");
endmodule

FILE: rtl/bbs_div.sv
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps
module bbs_div
	import bbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);
	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0] cnt_q;
	logic busy_q, neg_q, done_q;
	logic [64:0] trial;
	logic [63:0] shifted;

	always_comb begin
		shifted = {rem_q[62:0], quo_q[63]};
		trial = {1'b0, shifted} - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
				rem_q <= '0;
				quo_q <= req.num[63] ? 64'(-req.num) : req.num;
				den_q <= req.den[63] ? 64'(-req.den) : req.den;
				neg_q <= req.num[63] ^ req.den[63];
			end else if (busy_q) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Drop a completion of an abandoned division that lands on a new start.
	assign rsp.done = done_q && !req.start;
	assign rsp.quo = neg_q ? -$signed(quo_q) : $signed(quo_q);

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) req.start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q && !req.start |=>
		cnt_q == $past(cnt_q) + 7'd1 || done_q)
		else $error("divider count skipped");
endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the billboard sprite pixel shader.
`timescale 1ns / 1ps
module tb;
	import bbs_pkg::*;

	localparam int unsigned CycleLimit = 3000000;
	localparam int unsigned PhaseItems = 140;
	localparam logic [2:0] RegNone = 3'd7;
	localparam logic [2:0] RegSpare = 3'd6;

	typedef struct {
		cmd_t cmd;
		logic [9:0] column;
		logic [8:0] row;
		logic [5:0] tc;
		logic [5:0] tr;
		logic [23:0] texel;
		logic [23:0] wdepth;
		logic [23:0] sx;
		logic [23:0] sy;
	} item_t;

	typedef struct {
		logic draw;
		logic [23:0] color;
		logic [9:0] column;
		logic [8:0] row;
	} pixel_t;

	typedef struct {
		item_t it;
		pixel_t px;
	} job_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic [1:0] command = '0;
	logic [9:0] column = '0;
	logic [8:0] row = '0;
	logic [5:0] tex_col = '0, tex_row = '0;
	logic [23:0] texel_color = '0, wall_depth = '0, sprite_x = '0, sprite_y = '0;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic out_valid, out_ready = 1'b0;
	logic draw;
	logic [23:0] color;
	logic [9:0] out_column;
	logic [8:0] out_row;

	billboard_sprite_pixel_shader i_dut (.*);

	always #2 clk = ~clk;

	// predictor state
	logic [23:0] tex_mem [4096];
	bit tex_ok [4096];
	logic [23:0] depth_mem [ScreenW];
	bit depth_ok [ScreenW];
	longint plx, ply, drx, dry, pnx, pny;
	longint s_depth, s_center, s_h, bsx, bex, bsy, bey;

	job_t send_q[$];
	pixel_t pixel_q[$];
	int send_idle = 0, recv_stall = 0, hold_cnt = 0, fails = 0;
	bit in_busy = 0;
	longint unsigned cycles = 0;

	function automatic longint sat_i32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint lim(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void place_sprite(logic [23:0] sx, logic [23:0] sy);
		longint dx, dy, det, tn, dn, half;
		dx = longint'(sx) - plx;
		dy = longint'(sy) - ply;
		det = pnx * dry - pny * drx;
		tn = dry * dx - drx * dy;
		dn = pnx * dy - pny * dx;
		if (det == 0 || dn == 0) begin
			{s_depth, s_center, s_h, bsx, bex, bsy, bey} = '0;
			return;
		end
		s_depth = sat_i32((dn * 65536) / det);
		s_center = sat_i32((longint'(ScreenW / 2) * (tn + dn)) / dn);
		s_h = (longint'(ScreenH) * det) / dn;
		if (s_h < 0)
			s_h = -s_h;
		s_h = sat_i32(s_h);
		half = s_h / 2;
		bsy = lim(ScreenH / 2 - half, 0, ScreenH);
		bey = lim(ScreenH / 2 + half, 0, ScreenH);
		bsx = lim(s_center - half, 0, ScreenW);
		bex = lim(s_center + half, 0, ScreenW);
	endfunction

	// Texel address a query reads, if it gets that far; depth must be known.
	function automatic bit texel_addr(longint c, longint r, output int idx);
		longint half, tx, ty;
		idx = 0;
		half = s_h / 2;
		if (s_h <= 0 || s_depth <= 0 || c <= 0 || c >= ScreenW)
			return 0;
		if (c < bsx || c >= bex || r < bsy || r >= bey)
			return 0;
		if (s_depth >= longint'(depth_mem[c]))
			return 0;
		tx = (256 * (c - (s_center - half)) * TexSize / s_h) / 256;
		ty = ((r * 256 - longint'(ScreenH) * 128 + s_h * 128) * TexSize / s_h) / 256;
		tx = lim(tx, 0, TexSize - 1);
		ty = lim(ty, 0, TexSize - 1);
		idx = int'(ty * TexSize + tx);
		return 1;
	endfunction

	function automatic pixel_t shade_step(item_t it);
		pixel_t p;
		int idx;
		p = '{draw: 1'b0, color: '0, column: it.column, row: it.row};
		case (it.cmd)
			CMD_TEXEL: begin
				tex_mem[{it.tr, it.tc}] = it.texel;
				tex_ok[{it.tr, it.tc}] = 1;
			end
			CMD_DEPTH: begin
				if (it.column < ScreenW) begin
					depth_mem[it.column] = it.wdepth;
					depth_ok[it.column] = 1;
				end
			end
			CMD_SPRITE: place_sprite(it.sx, it.sy);
			default: begin
				if (texel_addr(it.column, it.row, idx) && tex_mem[idx] != Magenta) begin
					p.draw = 1'b1;
					p.color = tex_mem[idx];
				end
			end
		endcase
		return p;
	endfunction

	function automatic item_t noise(cmd_t cmd);
		item_t it;
		it.cmd = cmd;
		it.column = 10'($urandom);
		it.row = 9'($urandom);
		it.tc = 6'($urandom);
		it.tr = 6'($urandom);
		it.texel = 24'($urandom);
		it.wdepth = 24'($urandom);
		it.sx = 24'($urandom);
		it.sy = 24'($urandom);
		return it;
	endfunction

	function automatic void push_item(item_t it);
		job_t j;
		j.it = it;
		j.px = shade_step(it);
		send_q.push_back(j);
	endfunction

	function automatic void push_query(int c, int r);
		item_t it;
		int idx;
		if (c < ScreenW && !depth_ok[c]) begin
			it = noise(CMD_DEPTH);
			it.column = 10'(c);
			if ($urandom_range(0, 3) == 0)
				it.wdepth = 24'($urandom_range(0, 600000));
			push_item(it);
		end
		if (texel_addr(c, r, idx) && !tex_ok[idx]) begin
			it = noise(CMD_TEXEL);
			{it.tr, it.tc} = 12'(idx);
			if ($urandom_range(0, 7) == 0)
				it.texel = Magenta;
			push_item(it);
		end
		it = noise(CMD_QUERY);
		it.column = 10'(c);
		it.row = 9'(r);
		push_item(it);
	endfunction

	// Sprite ahead of the camera: player + k*dir + s*plane.
	function automatic void push_sprite_ahead();
		item_t it;
		longint k, s;
		k = longint'($urandom_range(32768, 8 * 65536));
		s = longint'($urandom_range(0, 131072)) - 65536;
		it = noise(CMD_SPRITE);
		it.sx = 24'(lim(plx + (k * drx + s * pnx) / 65536, 0, 24'hFFFFFF));
		it.sy = 24'(lim(ply + (k * dry + s * pny) / 65536, 0, 24'hFFFFFF));
		push_item(it);
	endfunction

	function automatic void push_random();
		item_t it;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 12) begin
			it = noise(CMD_TEXEL);
			if ($urandom_range(0, 7) == 0)
				it.texel = Magenta;
			push_item(it);
		end else if (sel < 20) begin
			it = noise(CMD_DEPTH);
			if ($urandom_range(0, 2) == 0)
				it.wdepth = 24'($urandom_range(0, 600000));
			push_item(it);
		end else if (sel < 25) begin
			push_sprite_ahead();
		end else if (sel < 28) begin
			push_item(noise(CMD_SPRITE));
		end else if (sel < 85 && bex > bsx && bey > bsy) begin
			push_query(int'(lim($urandom_range(0, 9) + bsx - 4, 0, 1023)) +
				$urandom_range(0, int'(bex - bsx)),
				int'(lim($urandom_range(0, int'(bey - bsy) + 8) + bsy - 4, 0, 511)));
		end else begin
			push_query($urandom_range(0, 1023), $urandom_range(0, 511));
		end
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [23:0] v);
		case (idx)
			REG_PLAYER_X: plx = longint'(v);
			REG_PLAYER_Y: ply = longint'(v);
			REG_DIR_X: drx = longint'(signed'(v[18:0]));
			REG_DIR_Y: dry = longint'(signed'(v[18:0]));
			REG_PLANE_X: pnx = longint'(signed'(v[18:0]));
			REG_PLANE_Y: pny = longint'(signed'(v[18:0]));
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Fill the upper bits of a signed Q16.16 register with junk.
	function automatic logic [23:0] vec(longint v);
		return {5'($urandom), 19'(v)};
	endfunction

	function automatic longint rnd_vec();
		return longint'($urandom_range(0, 262144)) - 131072;
	endfunction

	task automatic write_camera(longint dx, longint dy, longint px, longint py);
		write_reg(REG_DIR_X, vec(dx));
		write_reg(REG_DIR_Y, vec(dy));
		write_reg(REG_PLANE_X, vec(px));
		write_reg(REG_PLANE_Y, vec(py));
	endtask

	task automatic drain();
		wait (send_q.size() == 0 && !in_busy && pixel_q.size() == 0);
	endtask

	// driver
	always @(negedge clk) begin
		if (!in_busy) begin
			if (arst_n && send_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
				command <= send_q[0].it.cmd;
				column <= send_q[0].it.column;
				row <= send_q[0].it.row;
				tex_col <= send_q[0].it.tc;
				tex_row <= send_q[0].it.tr;
				texel_color <= send_q[0].it.texel;
				wall_depth <= send_q[0].it.wdepth;
				sprite_x <= send_q[0].it.sx;
				sprite_y <= send_q[0].it.sy;
				in_valid <= 1'b1;
				in_busy = 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver readiness, with the long hold-off counted here
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(0, 99) >= recv_stall);
		end
	end

	// monitor
	always @(posedge clk) begin
		pixel_t want;
		if (in_valid && in_ready) begin
			pixel_q.push_back(send_q[0].px);
			void'(send_q.pop_front());
			in_busy = 0;
		end
		if (out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				$error("result beat with nothing expected");
				fails++;
			end else begin
				want = pixel_q.pop_front();
				if (draw !== want.draw) begin
					$error("draw: expected %0d, got %0d", want.draw, draw);
					fails++;
				end
				if (color !== want.color) begin
					$error("color: expected %06h, got %06h", want.color, color);
					fails++;
				end
				if (out_column !== want.column) begin
					$error("out_column: expected %0d, got %0d", want.column, out_column);
					fails++;
				end
				if (out_row !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, out_row);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		item_t it;
		plx = 0;
		ply = 0;
		drx = 65536;
		dry = 0;
		pnx = 0;
		pny = 43254;
		{s_depth, s_center, s_h, bsx, bex, bsy, bey} = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 69; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 69; end
				default: begin send_idle = 26; recv_stall = 26; end
			endcase
			case (p)
				0: begin
					write_reg(REG_PLAYER_X, 24'h080000);
					write_reg(REG_PLAYER_Y, 24'h080000);
					write_camera(65536, 0, 0, 43254);
					write_reg(RegSpare, 24'($urandom));
					write_reg(RegNone, 24'($urandom));
				end
				1: begin
					write_reg(REG_PLAYER_X, 24'h000000);
					write_reg(REG_PLAYER_Y, 24'h000000);
					write_camera(131072, 0, 0, -131072);
				end
				2: begin
					write_reg(REG_PLAYER_X, 24'hFFFFFF);
					write_reg(REG_PLAYER_Y, 24'hFFFFFF);
					write_camera(-131072, -131072, -131072, 131072);
				end
				5: begin
					// plane parallel to dir: singular camera
					write_camera(65536, 0, 65536, 0);
				end
				default: begin
					write_reg(REG_PLAYER_X, 24'($urandom));
					write_reg(REG_PLAYER_Y, 24'($urandom));
					write_camera(rnd_vec(), rnd_vec(), rnd_vec(), rnd_vec());
				end
			endcase

			if (p == 0) begin
				it = noise(CMD_TEXEL); {it.tr, it.tc} = '0; it.texel = '0; push_item(it);
				it = noise(CMD_TEXEL); {it.tr, it.tc} = '1; it.texel = '1; push_item(it);
				it = noise(CMD_TEXEL); it.texel = Magenta; push_item(it);
				it = noise(CMD_DEPTH); it.column = 10'd0; it.wdepth = '1; push_item(it);
				it = noise(CMD_DEPTH); it.column = 10'd639; it.wdepth = '0; push_item(it);
				it = noise(CMD_DEPTH); it.column = 10'd640; push_item(it);
				it = noise(CMD_DEPTH); it.column = '1; push_item(it);
				// sprite three units ahead, slightly off axis
				it = noise(CMD_SPRITE); it.sx = 24'h0B0000; it.sy = 24'h083000;
				push_item(it);
				push_query(0, 240);
				push_query(639, 0);
				push_query(640, 240);
				push_query(1023, 511);
				push_query(int'(s_center), 240);
				push_query(int'(bsx), int'(bsy));
				push_query(int'(bex) - 1, int'(bey) - 1);
				push_query(int'(s_center), 479);
				// sprite on the player: zero depth numerator
				it = noise(CMD_SPRITE); it.sx = 24'h080000; it.sy = 24'h080000;
				push_item(it);
				push_query(int'(320), 240);
				// sprite behind the camera
				it = noise(CMD_SPRITE); it.sx = 24'h050000; it.sy = 24'h080000;
				push_item(it);
				push_query(320, 240);
				it = noise(CMD_SPRITE); it.sx = '1; it.sy = '0; push_item(it);
				push_query($urandom_range(1, 639), $urandom_range(0, 479));
			end

			if (p == 2)
				hold_cnt = 400;
			for (int n = 0; n < PhaseItems; n++) begin
				if (n == PhaseItems / 2)
					drain();
				if (n % 40 == 0)
					push_sprite_ahead();
				push_random();
			end
			drain();
		end

		repeat (300) @(posedge clk);
		if (fails == 0 && pixel_q.size() == 0 && send_q.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule

FILE: sim.f
rtl/bbs_pkg.sv
rtl/bbs_div.sv
rtl/billboard_sprite_pixel_shader.sv
tb/sv/tb.sv
